// File: design/crcfp_pkg.sv
package crcfp_pkg;

	// Controller states: the eight parse phases, then the two-step payload readout.
	typedef enum logic [3:0] {
		ST_MAGIC1,
		ST_MAGIC2,
		ST_ID,
		ST_LEN,
		ST_SEQ,
		ST_PAYLOAD,
		ST_CRC_LO,
		ST_CRC_HI,
		ST_RD,
		ST_LOAD
	} state_t;

	typedef enum logic [1:0] {
		CRC_HOLD,
		CRC_INIT,
		CRC_STEP
	} crc_op_t;

	// Result kinds carried on tuser.
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_LEN_ERR = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
	localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
	localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;

	localparam logic [15:0] CRC_INIT_VAL = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'h1021;
	localparam logic [5:0]  MAX_PAYLOAD_RESET = 6'd32;

	localparam int TDATA_W = 40;

	typedef struct packed {
		crc_op_t crc_op;
		logic    restart;
		logic    latch_id;
		logic    latch_len;
		logic    latch_seq;
		logic    clear_fill;
		logic    store_byte;
		logic    latch_crc_lo;
		logic    load_err;
		logic    load_hdr;
		logic    load_pay;
		logic    rd_clear;
		logic    rd_en;
		logic    rd_adv;
	} cmd_t;

	typedef struct packed {
		logic is_magic1;
		logic is_magic2;
		logic len_over;
		logic len_zero;
		logic fill_done;
		logic crc_ok;
		logic emit_last;
		logic out_free;
	} status_t;

	// One byte of CRC-16/CCITT-FALSE, MSB first.
	function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: design/crcfp_ctrl.sv
module crcfp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  crcfp_pkg::status_t  st,
	output crcfp_pkg::cmd_t     cmd
);

	crcfp_pkg::state_t state_q, state_d;
	logic acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crcfp_pkg::ST_MAGIC1;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.crc_op = crcfp_pkg::CRC_HOLD;
		s_tready = 1'b0;
		acc      = 1'b0;
		case (state_q)
			crcfp_pkg::ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = crcfp_pkg::ST_LOAD;
			end
			crcfp_pkg::ST_LOAD: begin
				if (st.out_free) begin
					cmd.load_pay = 1'b1;
					cmd.rd_adv   = 1'b1;
					if (st.emit_last) begin
						cmd.restart = 1'b1;
						state_d     = crcfp_pkg::ST_MAGIC1;
					end else begin
						state_d = crcfp_pkg::ST_RD;
					end
				end
			end
			default: begin
				// Every parse phase waits for a free output slot, since the length and CRC high phases may load a result.
				s_tready = st.out_free;
				acc      = s_tvalid && st.out_free;
				if (acc) begin
					case (state_q)
						crcfp_pkg::ST_MAGIC1: begin
							if (st.is_magic1) begin
								cmd.crc_op = crcfp_pkg::CRC_INIT;
								state_d    = crcfp_pkg::ST_MAGIC2;
							end
						end
						crcfp_pkg::ST_MAGIC2: begin
							if (!st.is_magic2) begin
								cmd.restart = 1'b1;
								if (st.is_magic1) begin
									cmd.crc_op = crcfp_pkg::CRC_INIT;
									state_d    = crcfp_pkg::ST_MAGIC2;
								end else begin
									state_d = crcfp_pkg::ST_MAGIC1;
								end
							end else begin
								cmd.crc_op = crcfp_pkg::CRC_STEP;
								state_d    = crcfp_pkg::ST_ID;
							end
						end
						crcfp_pkg::ST_ID: begin
							cmd.latch_id = 1'b1;
							cmd.crc_op   = crcfp_pkg::CRC_STEP;
							state_d      = crcfp_pkg::ST_LEN;
						end
						crcfp_pkg::ST_LEN: begin
							cmd.latch_len = 1'b1;
							if (st.len_over) begin
								cmd.load_err = 1'b1;
								cmd.restart  = 1'b1;
								state_d      = crcfp_pkg::ST_MAGIC1;
							end else begin
								cmd.crc_op = crcfp_pkg::CRC_STEP;
								state_d    = crcfp_pkg::ST_SEQ;
							end
						end
						crcfp_pkg::ST_SEQ: begin
							cmd.latch_seq  = 1'b1;
							cmd.crc_op     = crcfp_pkg::CRC_STEP;
							cmd.clear_fill = 1'b1;
							state_d = st.len_zero ? crcfp_pkg::ST_CRC_LO : crcfp_pkg::ST_PAYLOAD;
						end
						crcfp_pkg::ST_PAYLOAD: begin
							cmd.store_byte = 1'b1;
							cmd.crc_op     = crcfp_pkg::CRC_STEP;
							if (st.fill_done) begin
								state_d = crcfp_pkg::ST_CRC_LO;
							end
						end
						crcfp_pkg::ST_CRC_LO: begin
							cmd.latch_crc_lo = 1'b1;
							state_d          = crcfp_pkg::ST_CRC_HI;
						end
						crcfp_pkg::ST_CRC_HI: begin
							if (st.crc_ok && !st.len_zero) begin
								cmd.rd_clear = 1'b1;
								state_d      = crcfp_pkg::ST_RD;
							end else begin
								cmd.load_hdr = st.crc_ok;
								cmd.restart  = 1'b1;
								state_d      = crcfp_pkg::ST_MAGIC1;
							end
						end
						default: begin
							state_d = crcfp_pkg::ST_MAGIC1;
						end
					endcase
				end
			end
		endcase
	end

endmodule

// File: design/crcfp_dp.sv
module crcfp_dp #(
	parameter int PAYLOAD_MAX = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [7:0]                    in_byte,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [7:0]                    cfg_data,
	input  crcfp_pkg::cmd_t               cmd,
	output crcfp_pkg::status_t            st,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [crcfp_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast
);

	localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
	localparam logic [7:0] PMAX8 = 8'(PAYLOAD_MAX);

	logic [7:0]  magic_first_q, magic_second_q;
	logic [5:0]  max_payload_q;
	logic [7:0]  held_id_q, held_len_q, held_seq_q, crc_lo_q;
	logic [5:0]  fill_q, fill_nxt;
	logic [5:0]  rd_q;
	logic [15:0] crc_q;
	logic [7:0]  mem [PAYLOAD_MAX];
	logic [7:0]  rd_data_q;
	logic [7:0]  limit, cnt;

	logic [1:0]  kind_q;
	logic [7:0]  id_q, seq_q, len_q, data_q;
	logic [4:0]  idx_q;
	logic        last_q, valid_q;

	assign limit    = ({2'b00, max_payload_q} > PMAX8) ? PMAX8 : {2'b00, max_payload_q};
	assign cnt      = (held_len_q > PMAX8) ? PMAX8 : held_len_q;
	assign fill_nxt = fill_q + 6'd1;

	always_comb begin
		st.is_magic1 = (in_byte == magic_first_q);
		st.is_magic2 = (in_byte == magic_second_q);
		st.len_over  = (in_byte > limit);
		st.len_zero  = (held_len_q == 8'd0);
		st.fill_done = ({2'b00, fill_nxt} >= held_len_q);
		st.crc_ok    = ({in_byte, crc_lo_q} == crc_q);
		st.emit_last = (({2'b00, rd_q} + 8'd1) == cnt);
		st.out_free  = !valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q  <= 8'd0;
			magic_second_q <= 8'd0;
			max_payload_q  <= crcfp_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				crcfp_pkg::REG_MAGIC_FIRST:  magic_first_q  <= cfg_data;
				crcfp_pkg::REG_MAGIC_SECOND: magic_second_q <= cfg_data;
				crcfp_pkg::REG_MAX_PAYLOAD:  max_payload_q  <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_id_q  <= 8'd0;
			held_len_q <= 8'd0;
			held_seq_q <= 8'd0;
			crc_lo_q   <= 8'd0;
			fill_q     <= 6'd0;
			rd_q       <= 6'd0;
			crc_q      <= crcfp_pkg::CRC_INIT_VAL;
		end else begin
			if (cmd.restart) begin
				held_id_q  <= 8'd0;
				held_len_q <= 8'd0;
				held_seq_q <= 8'd0;
				crc_lo_q   <= 8'd0;
				fill_q     <= 6'd0;
			end else begin
				if (cmd.latch_id)     held_id_q  <= in_byte;
				if (cmd.latch_len)    held_len_q <= in_byte;
				if (cmd.latch_seq)    held_seq_q <= in_byte;
				if (cmd.latch_crc_lo) crc_lo_q   <= in_byte;
				if (cmd.clear_fill) begin
					fill_q <= 6'd0;
				end else if (cmd.store_byte) begin
					fill_q <= fill_nxt;
				end
			end
			// Seeding from a first magic byte wins over a restart, so a wrong second magic
			// byte that is itself a first magic byte begins a new frame.
			if (cmd.crc_op == crcfp_pkg::CRC_INIT) begin
				crc_q <= crcfp_pkg::crc_step(crcfp_pkg::CRC_INIT_VAL, in_byte);
			end else if (cmd.restart) begin
				crc_q <= crcfp_pkg::CRC_INIT_VAL;
			end else if (cmd.crc_op == crcfp_pkg::CRC_STEP) begin
				crc_q <= crcfp_pkg::crc_step(crc_q, in_byte);
			end
			if (cmd.rd_clear) begin
				rd_q <= 6'd0;
			end else if (cmd.rd_adv) begin
				rd_q <= rd_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_byte && ({1'b0, fill_q} < 7'(PAYLOAD_MAX))) begin
			mem[fill_q[AW-1:0]] <= in_byte;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load_err || cmd.load_hdr || cmd.load_pay) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			kind_q <= crcfp_pkg::KIND_LEN_ERR;
			id_q   <= held_id_q;
			seq_q  <= 8'd0;
			len_q  <= in_byte;
			idx_q  <= 5'd0;
			data_q <= 8'd0;
			last_q <= 1'b1;
		end else if (cmd.load_hdr) begin
			kind_q <= crcfp_pkg::KIND_HEADER;
			id_q   <= held_id_q;
			seq_q  <= held_seq_q;
			len_q  <= held_len_q;
			idx_q  <= 5'd0;
			data_q <= 8'd0;
			last_q <= 1'b1;
		end else if (cmd.load_pay) begin
			kind_q <= crcfp_pkg::KIND_PAYLOAD;
			id_q   <= held_id_q;
			seq_q  <= held_seq_q;
			len_q  <= held_len_q;
			idx_q  <= rd_q[4:0];
			data_q <= rd_data_q;
			last_q <= st.emit_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {3'b000, data_q, idx_q, len_q, seq_q, id_q};

endmodule

// File: design/crc_checked_frame_parser.sv
// Latency: a length error or an empty good frame is shown the cycle after its byte is taken.
// A good frame with payload starts its burst after the CRC high byte, each result passing
// ST_RD then ST_LOAD (registered payload memory read, then output load); no bytes are taken meanwhile.
// Throughput: one byte per cycle while parsing, held off while a result waits on m_tready.
// Reset (arst_n low, asynchronous): parser waits for a first magic byte, registers return to
// their reset values; the payload memory is not cleared and needs no clearing pass.
module crc_checked_frame_parser #(
	parameter int PAYLOAD_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Received byte stream. s_tdata fields from bit 0: in_byte[7:0].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// Results. m_tdata fields from bit 0: frame_id[7:0], frame_seq[15:8], frame_len[23:16],
	// byte_index[28:24], data_byte[36:29], zero fill [39:37].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	// m_tuser fields from bit 0: kind[1:0].
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	// Configuration write channel: index 0 magic_first, 1 magic_second, 2 max_payload.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	crcfp_pkg::cmd_t    cmd;
	crcfp_pkg::status_t st;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	// The controller sequences the frame phases and the payload readout.
	crcfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds the header fields, the running CRC, the payload memory,
	// the configuration registers and the output register.
	crcfp_dp #(
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
